### rtl/connection_liveness_timeout_table_defines.svh
// assertion macros for the connection liveness timeout table
// used by clt_front and clt_engine, no other dependencies
`ifndef CONNECTION_LIVENESS_TIMEOUT_TABLE_DEFINES_SVH
`define CONNECTION_LIVENESS_TIMEOUT_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define CLT_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("clt assertion failed");
`define CLT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("clt assertion failed");
`else
`define CLT_ASSERT(lbl, ck, rn, prop)
`define CLT_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

### rtl/clt_pkg.sv
// shared widths, codes and types of the connection liveness timeout table
// no dependencies
`timescale 1ns / 1ps
package clt_pkg;

  localparam int OP_W  = 2;
  localparam int ID_W  = 6;
  localparam int SEC_W = 31;
  localparam int ST_W  = 3;

  localparam logic [OP_W-1:0] OP_OPEN    = 2'd0;
  localparam logic [OP_W-1:0] OP_REFRESH = 2'd1;
  localparam logic [OP_W-1:0] OP_CLOSE   = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_ALREADY   = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_EXPIRED   = 3'd3;
  localparam logic [ST_W-1:0] ST_NONE      = 3'd4;

  localparam logic [SEC_W-1:0] TIMEOUT_RESET = 31'd40;

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QCW    = 2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [SEC_W-1:0] now_sec;
    logic             in_range;
  } item_t;

endpackage

### rtl/clt_if.sv
// valid/ready channel interfaces for input words and result words
// depends on clt_pkg
`timescale 1ns / 1ps
interface clt_in_if;
  logic                      valid;
  logic                      ready;
  logic [clt_pkg::OP_W-1:0]  operation;
  logic [clt_pkg::ID_W-1:0]  conn_id;
  logic [clt_pkg::SEC_W-1:0] now_sec;

  modport source (output valid, output operation, output conn_id, output now_sec,
                  input ready);
  modport sink (input valid, input operation, input conn_id, input now_sec,
                output ready);
endinterface

interface clt_out_if;
  logic                      valid;
  logic                      ready;
  logic [clt_pkg::ST_W-1:0]  status;
  logic [clt_pkg::ID_W-1:0]  slot_id;
  logic [clt_pkg::SEC_W-1:0] seen_sec;
  logic                      last;

  modport source (output valid, output status, output slot_id, output seen_sec,
                  output last, input ready);
  modport sink (input valid, input status, input slot_id, input seen_sec,
                input last, output ready);
endinterface

### rtl/clt_front.sv
// front end: accepts input words, flags out-of-table slots, queues them
// depends on clt_pkg, clt_if and the assertion macro header
`timescale 1ns / 1ps
`include "connection_liveness_timeout_table_defines.svh"
module clt_front #(
  parameter int MAX_CONN = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  clt_in_if.sink         in_ch,
  output logic           q_vld,
  output clt_pkg::item_t q_item,
  input  logic           q_pop
);

  clt_pkg::item_t         q_mem [clt_pkg::QDEPTH];
  logic [clt_pkg::QAW-1:0] wr_ptr_r;
  logic [clt_pkg::QAW-1:0] rd_ptr_r;
  logic [clt_pkg::QCW-1:0] q_cnt_r;
  logic                    push;
  logic                    pop;
  clt_pkg::item_t          new_item;

  assign in_ch.ready = q_cnt_r != clt_pkg::QCW'(clt_pkg::QDEPTH);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_pop && q_vld;
  assign q_vld       = q_cnt_r != '0;
  assign q_item      = q_mem[rd_ptr_r];

  always_comb begin
    new_item.op       = in_ch.operation;
    new_item.id       = in_ch.conn_id;
    new_item.now_sec  = in_ch.now_sec;
    new_item.in_range = {1'b0, in_ch.conn_id} < (clt_pkg::ID_W + 1)'(MAX_CONN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        q_cnt_r <= q_cnt_r + 1'b1;
      end else if (pop && !push) begin
        q_cnt_r <= q_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_item;
    end
  end

  `CLT_ASSERT(a_cnt_bound, clk, rst_n, q_cnt_r <= clt_pkg::QCW'(clt_pkg::QDEPTH))
  `CLT_ASSERT(a_pop_nonempty, clk, rst_n, q_pop |-> q_cnt_r != '0)
  `CLT_ASSERT_NEXT(a_push_pop_hold, clk, rst_n, push && pop, q_cnt_r == $past(q_cnt_r))

endmodule

### rtl/clt_engine.sv
// back end: slot table with live bits and stamp memory, tick scan, result register
// depends on clt_pkg, clt_if and the assertion macro header
`timescale 1ns / 1ps
`include "connection_liveness_timeout_table_defines.svh"
module clt_engine #(
  parameter int MAX_CONN = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_vld,
  input  clt_pkg::item_t            q_item,
  output logic                      q_pop,
  input  logic [clt_pkg::SEC_W-1:0] timeout_sec,
  clt_out_if.source                 out_ch
);

  localparam int IDW = (MAX_CONN > 1) ? $clog2(MAX_CONN) : 1;
  localparam int CW  = $clog2(MAX_CONN + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]               state_r;
  logic [1:0]               state_nxt;
  logic [MAX_CONN-1:0]      live_r;
  logic [clt_pkg::SEC_W-1:0] stamp_mem [MAX_CONN];
  logic [clt_pkg::SEC_W-1:0] rd_stamp_r;
  logic [IDW-1:0]           rd_addr;
  logic                     chk_vld_r;
  logic [IDW-1:0]           chk_idx_r;
  logic [CW-1:0]            scan_idx_r;
  logic [clt_pkg::SEC_W-1:0] now_r;
  logic [CW-1:0]            rem_r;
  logic                     first_r;
  logic                     best_vld_r;
  logic [IDW-1:0]           best_id_r;
  logic [clt_pkg::SEC_W-1:0] best_stamp_r;

  logic                     out_vld_r;
  logic [clt_pkg::ST_W-1:0] out_status_r;
  logic [clt_pkg::ID_W-1:0] out_slot_r;
  logic [clt_pkg::SEC_W-1:0] out_seen_r;
  logic                     out_last_r;

  logic                     out_free;
  logic                     is_tick;
  logic [IDW-1:0]           item_idx;
  logic                     item_live;
  logic                     take_cmd;
  logic                     take_tick;
  logic                     issue;
  logic [clt_pkg::SEC_W:0]  diff;
  logic                     aged;
  logic                     cand;
  logic                     better;
  logic                     scan_done;
  logic                     emit_none;
  logic                     emit_exp;
  logic [clt_pkg::ST_W-1:0] cmd_status;
  logic                     cmd_set_live;
  logic                     cmd_clr_live;
  logic                     cmd_wr;

  assign out_free  = !out_vld_r || out_ch.ready;
  assign is_tick   = q_item.op == clt_pkg::OP_TICK;
  assign item_idx  = q_item.id[IDW-1:0];
  assign item_live = q_item.in_range && live_r[item_idx];
  assign take_cmd  = (state_r == S_IDLE) && q_vld && !is_tick && out_free;
  assign take_tick = (state_r == S_IDLE) && q_vld && is_tick;
  assign q_pop     = take_cmd || take_tick;

  assign issue     = (state_r == S_SCAN) && (scan_idx_r < CW'(MAX_CONN));
  assign rd_addr   = issue ? scan_idx_r[IDW-1:0] : '0;
  // signed age: a stamp ahead of now never expires
  assign diff      = {1'b0, now_r} - {1'b0, rd_stamp_r};
  assign aged      = !diff[clt_pkg::SEC_W] && (diff[clt_pkg::SEC_W-1:0] > timeout_sec);
  assign cand      = chk_vld_r && live_r[chk_idx_r] && aged;
  assign better    = cand && (!best_vld_r || (rd_stamp_r < best_stamp_r));
  assign scan_done = chk_vld_r && (chk_idx_r == IDW'(MAX_CONN - 1));
  assign emit_none = (state_r == S_EMIT) && first_r && (rem_r == '0) && out_free;
  assign emit_exp  = (state_r == S_EMIT) && !(first_r && (rem_r == '0)) && out_free;

  always_comb begin
    cmd_status   = clt_pkg::ST_NOT_FOUND;
    cmd_set_live = 1'b0;
    cmd_clr_live = 1'b0;
    cmd_wr       = 1'b0;
    if (q_item.in_range) begin
      unique case (q_item.op)
        clt_pkg::OP_OPEN: begin
          if (item_live) begin
            cmd_status = clt_pkg::ST_ALREADY;
          end else begin
            cmd_status   = clt_pkg::ST_OK;
            cmd_set_live = 1'b1;
            cmd_wr       = 1'b1;
          end
        end
        clt_pkg::OP_REFRESH: begin
          if (item_live) begin
            cmd_status = clt_pkg::ST_OK;
            cmd_wr     = 1'b1;
          end
        end
        clt_pkg::OP_CLOSE: begin
          if (item_live) begin
            cmd_status   = clt_pkg::ST_OK;
            cmd_clr_live = 1'b1;
          end
        end
        clt_pkg::OP_TICK: begin
          cmd_status = clt_pkg::ST_NOT_FOUND;
        end
        default: begin
          cmd_status = clt_pkg::ST_NOT_FOUND;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take_tick) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_none) begin
          state_nxt = S_IDLE;
        end else if (emit_exp) begin
          state_nxt = (rem_r == CW'(1)) ? S_IDLE : S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      live_r     <= '0;
      chk_vld_r  <= 1'b0;
      scan_idx_r <= '0;
      rem_r      <= '0;
      first_r    <= 1'b0;
      best_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= issue;
      if (take_cmd && cmd_set_live) begin
        live_r[item_idx] <= 1'b1;
      end
      if (take_cmd && cmd_clr_live) begin
        live_r[item_idx] <= 1'b0;
      end
      if (take_tick) begin
        scan_idx_r <= '0;
        rem_r      <= '0;
        first_r    <= 1'b1;
        best_vld_r <= 1'b0;
      end
      if (issue) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (cand && first_r) begin
        rem_r <= rem_r + 1'b1;
      end
      if (better) begin
        best_vld_r <= 1'b1;
      end
      if (emit_exp) begin
        live_r[best_id_r] <= 1'b0;
        rem_r             <= rem_r - 1'b1;
        first_r           <= 1'b0;
        best_vld_r        <= 1'b0;
        scan_idx_r        <= '0;
      end
      if (take_cmd || emit_none || emit_exp) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // stamp memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (take_cmd && cmd_wr) begin
      stamp_mem[item_idx] <= q_item.now_sec;
    end
    rd_stamp_r <= stamp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= scan_idx_r[IDW-1:0];
    if (take_tick) begin
      now_r <= q_item.now_sec;
    end
    if (better) begin
      best_id_r    <= chk_idx_r;
      best_stamp_r <= rd_stamp_r;
    end
    if (take_cmd) begin
      out_status_r <= cmd_status;
      out_slot_r   <= q_item.id;
      out_seen_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (emit_none) begin
      out_status_r <= clt_pkg::ST_NONE;
      out_slot_r   <= '0;
      out_seen_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (emit_exp) begin
      out_status_r <= clt_pkg::ST_EXPIRED;
      out_slot_r   <= clt_pkg::ID_W'(best_id_r);
      out_seen_r   <= best_stamp_r;
      out_last_r   <= rem_r == CW'(1);
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.slot_id  = out_slot_r;
  assign out_ch.seen_sec = out_seen_r;
  assign out_ch.last     = out_last_r;

  `CLT_ASSERT(a_chk_in_scan, clk, rst_n, chk_vld_r |-> state_r == S_SCAN)
  `CLT_ASSERT(a_expired_live, clk, rst_n, emit_exp |-> best_vld_r && live_r[best_id_r])
  `CLT_ASSERT_NEXT(a_last_to_idle, clk, rst_n, emit_exp && rem_r == CW'(1), state_r == S_IDLE)

endmodule

### rtl/connection_liveness_timeout_table.sv
// channel   | dir | payload                               | handshake
// in_ch     | in  | operation, conn_id, now_sec           | valid/ready
// out_ch    | out | status, slot_id, seen_sec, last       | valid/ready
// apb       | in  | timeout_sec at byte address 0         | psel/penable, pready tied high
// open, refresh, close: one word per cycle while no tick scan runs and out_ch is ready
// tick: one scan of all MAX_CONN slots through the single stamp memory read port per
//   result; a tick with k expired slots takes max(1, k) scans
// two-entry input queue takes up to two words while the engine scans or the output stalls
// reset: synchronous active-low, clears live bits, queue and handshake state at once
// top level: apb register, front end and table engine; depends on clt_pkg and clt_if
`timescale 1ns / 1ps
module connection_liveness_timeout_table #(
  parameter int MAX_CONN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  clt_in_if.sink      in_ch,
  clt_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [clt_pkg::SEC_W-1:0] timeout_r;
  logic                      q_vld;
  clt_pkg::item_t            q_item;
  logic                      q_pop;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = !paddr[2];
  assign prdata  = reg_sel ? {1'b0, timeout_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= clt_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      timeout_r <= pwdata[clt_pkg::SEC_W-1:0];
    end
  end

  clt_front #(
    .MAX_CONN(MAX_CONN)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_vld (q_vld),
    .q_item(q_item),
    .q_pop (q_pop)
  );

  clt_engine #(
    .MAX_CONN(MAX_CONN)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .timeout_sec(timeout_r),
    .out_ch     (out_ch)
  );

endmodule
